// File: hdl/sps_pkg.sv
// sps_pkg: shared types and constants for the servo pulse train sequencer
// no dependencies; imported by sps_seq, servo_pulse_train_sequencer and sps_checker
package sps_pkg;

   // stages in each external shift register
   localparam int STAGES_PER_REGISTER = 4;

   // field widths
   localparam int FRAME_W   = 24;
   localparam int WIDTH_W   = 16;
   localparam int CHANNEL_W = 3;

   // reset values
   localparam logic [FRAME_W-1:0] FRAME_RESET = 24'd25000;
   localparam logic [WIDTH_W-1:0] MIDPOINT    = 16'd1500;

   // operation codes carried on req_tuser
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // pin level bit positions
   localparam int PIN_RESET_FIRST  = 0;
   localparam int PIN_DATA_FIRST   = 1;
   localparam int PIN_RESET_SECOND = 2;
   localparam int PIN_DATA_SECOND  = 3;

   // one decoded request toward the sequencer
   typedef struct packed {
      logic                 write_en;
      logic                 tick_en;
      logic [CHANNEL_W-1:0] channel;
      logic [WIDTH_W-1:0]   width_ticks;
   } sps_cmd_type;

   // one result word
   typedef struct packed {
      logic               is_gap;
      logic               data_second;
      logic               reset_second;
      logic               data_first;
      logic               reset_first;
      logic               clock_to_second;
      logic [FRAME_W-1:0] period_ticks;
   } sps_rsp_type;

endpackage

// File: hdl/sps_seq.sv
// sps_seq: channel position sequencer, pulse width store and frame budget
// depends on sps_pkg
module sps_seq import sps_pkg::*; #(
   parameter int CHANNELS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  sps_cmd_type        cmd,
   input  logic [FRAME_W-1:0] frame_ticks,
   output sps_rsp_type        rsp_next
);

   localparam int POS_W = $clog2(CHANNELS + 1);
   localparam int IDX_W = $clog2(CHANNELS);
   localparam logic [POS_W-1:0] POS_LAST   = POS_W'(CHANNELS);
   localparam logic [POS_W-1:0] POS_SECOND = POS_W'(STAGES_PER_REGISTER);

   logic [WIDTH_W-1:0] widths_ff [CHANNELS];
   logic [POS_W-1:0]   position_ff, position_in;
   logic [FRAME_W-1:0] remaining_ff, remaining_in;
   logic [3:0]         pins_ff, pins_in;
   logic               side_ff, side_in;

   logic [WIDTH_W-1:0] cur_width;
   logic [FRAME_W-1:0] cur_width_ext;
   logic [FRAME_W-1:0] base;
   logic [FRAME_W-1:0] floored;
   logic               gap;
   logic               write_ok;

   // width of the channel at the current position
   always_comb begin
      cur_width = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (position_ff == POS_W'(i)) begin
            cur_width = widths_ff[i];
         end
      end
   end

   // subtract from the frame budget, floored at zero
   assign cur_width_ext = {{(FRAME_W-WIDTH_W){1'b0}}, cur_width};
   assign base          = (position_ff == '0) ? frame_ticks : remaining_ff;
   assign floored       = (base > cur_width_ext) ? (base - cur_width_ext) : '0;
   assign gap           = (position_ff >= POS_LAST);

   // next position, pins and clock side
   always_comb begin
      pins_in      = pins_ff;
      side_in      = side_ff;
      remaining_in = floored;
      position_in  = position_ff + POS_W'(1);
      if (position_ff == '0) begin
         pins_in[PIN_RESET_FIRST] = 1'b0;
         pins_in[PIN_DATA_FIRST]  = 1'b1;
         side_in                  = 1'b0;
      end else if (position_ff < POS_SECOND) begin
         pins_in[PIN_DATA_FIRST] = 1'b0;
      end else if (position_ff == POS_SECOND) begin
         pins_in[PIN_RESET_FIRST]  = 1'b1;
         pins_in[PIN_RESET_SECOND] = 1'b0;
         pins_in[PIN_DATA_SECOND]  = 1'b1;
         side_in                   = 1'b1;
      end else if (!gap) begin
         pins_in[PIN_DATA_SECOND] = 1'b0;
      end else begin
         pins_in[PIN_RESET_SECOND] = 1'b1;
         remaining_in              = remaining_ff;
         position_in               = '0;
      end
   end

   // result word for a tick
   always_comb begin
      rsp_next.period_ticks    = gap ? remaining_ff : cur_width_ext;
      rsp_next.clock_to_second = side_in;
      rsp_next.reset_first     = pins_in[PIN_RESET_FIRST];
      rsp_next.data_first      = pins_in[PIN_DATA_FIRST];
      rsp_next.reset_second    = pins_in[PIN_RESET_SECOND];
      rsp_next.data_second     = pins_in[PIN_DATA_SECOND];
      rsp_next.is_gap          = gap;
   end

   assign write_ok = cmd.write_en && ({1'b0, cmd.channel} < 4'(CHANNELS));

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            widths_ff[i] <= MIDPOINT;
         end
         position_ff  <= '0;
         remaining_ff <= '0;
         pins_ff      <= '0;
         side_ff      <= 1'b1;
      end else begin
         if (write_ok) begin
            widths_ff[cmd.channel[IDX_W-1:0]] <= cmd.width_ticks;
         end
         if (cmd.tick_en) begin
            position_ff  <= position_in;
            remaining_ff <= remaining_in;
            pins_ff      <= pins_in;
            side_ff      <= side_in;
         end
      end
   end

endmodule

// File: hdl/servo_pulse_train_sequencer.sv
// servo_pulse_train_sequencer: top level, handshake, frame register and result register
// depends on sps_pkg and sps_seq
//
//  channel | direction | payload
//  req_*   | in        | tuser: operation; tdata: channel[2:0], width_ticks[18:3]
//  rsp_*   | out       | tuser: is_gap; tdata: period_ticks[23:0], pins and side [28:24]
//  csr_*   | in        | frame_ticks, write only
//
// one word is accepted per cycle while req_tready is high; a tick yields its result in the next cycle
// in the result register, a width write yields nothing
// the result register frees itself in the cycle it is taken, so req_tready
// drops only while a result waits and rsp_tready is low
// reset is synchronous: all widths to midpoint, position and pins to zero
module servo_pulse_train_sequencer import sps_pkg::*; #(
   parameter int CHANNELS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [23:0]        req_tdata,   // channel[2:0], width_ticks[18:3], zero pad
   input  logic               req_tuser,   // operation[0]
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [31:0]        rsp_tdata,   // period_ticks[23:0], clock_to_second[24],
                                           // reset_first[25], data_first[26],
                                           // reset_second[27], data_second[28], zero pad
   output logic               rsp_tuser,   // is_gap[0]
   input  logic               csr_we,
   input  logic [FRAME_W-1:0] csr_wdata
);

   logic [FRAME_W-1:0] frame_ff;
   logic               rsp_valid_ff;
   sps_rsp_type        rsp_word_ff;
   sps_rsp_type        rsp_next;
   sps_cmd_type        cmd;
   logic               req_fire;

   // accept while the result register is empty or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   // decode the request word
   always_comb begin
      cmd.write_en    = req_fire && (req_tuser == OP_WRITE);
      cmd.tick_en     = req_fire && (req_tuser == OP_TICK);
      cmd.channel     = req_tdata[CHANNEL_W-1:0];
      cmd.width_ticks = req_tdata[CHANNEL_W+WIDTH_W-1:CHANNEL_W];
   end

   sps_seq #(
      .CHANNELS (CHANNELS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .frame_ticks (frame_ff),
      .rsp_next    (rsp_next)
   );

   // frame length register
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= FRAME_RESET;
      end else if (csr_we) begin
         frame_ff <= csr_wdata;
      end
   end

   // result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.tick_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (cmd.tick_en) begin
         rsp_word_ff <= rsp_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000,
                        rsp_word_ff.data_second,
                        rsp_word_ff.reset_second,
                        rsp_word_ff.data_first,
                        rsp_word_ff.reset_first,
                        rsp_word_ff.clock_to_second,
                        rsp_word_ff.period_ticks};
   assign rsp_tuser  = rsp_word_ff.is_gap;

endmodule

// File: hdl/sps_checker.sv
// sps_checker: port-level checks on servo_pulse_train_sequencer, bound to the top level
// depends on sps_pkg
module sps_checker import sps_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_tvalid,
   input logic               req_tready,
   input logic               req_tuser,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [31:0]        rsp_tdata,
   input logic               rsp_tuser
);

   // a waiting result stays until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // a width write into an empty output produces no result
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_WRITE) && !rsp_tvalid |=> !rsp_tvalid)
      else $error("width write produced a result");

   // clocking the first register means its reset is released
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[24] |-> !rsp_tdata[25])
      else $error("first register clocked while held in reset");

   // the filler gap comes with both registers held in reset
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[25] && rsp_tdata[27])
      else $error("gap issued with a register out of reset");

endmodule

bind servo_pulse_train_sequencer sps_checker u_sps_checker (.*);

// File: sim/testbench.sv
// testbench: directed and random check of servo_pulse_train_sequencer against an in-bench
// model of its channel sequence, pin levels and frame gap; depends on sps_pkg and the rtl
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import sps_pkg::*;

   localparam int NUM_CHANNELS     = 8;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES    = 8;

   // one request word as the bench sees it
   typedef struct packed {
      logic                 op;
      logic [CHANNEL_W-1:0] channel;
      logic [WIDTH_W-1:0]   width_ticks;
   } servo_word_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [23:0]        req_tdata = '0;   // channel[2:0], width_ticks[18:3], zero pad
   logic               req_tuser = 1'b0; // operation[0]
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [31:0]        rsp_tdata;        // period_ticks[23:0], clock_to_second[24],
                                         // reset_first[25], data_first[26],
                                         // reset_second[27], data_second[28], zero pad
   logic               rsp_tuser;        // is_gap[0]
   logic               csr_we = 1'b0;
   logic [FRAME_W-1:0] csr_wdata = '0;

   // bench copy of the sequencer state
   logic [WIDTH_W-1:0] seq_widths [NUM_CHANNELS];
   logic [3:0]         seq_position;
   logic [FRAME_W-1:0] seq_remaining;
   logic [3:0]         seq_pins;
   logic               seq_side;
   logic [FRAME_W-1:0] seq_frame;

   servo_word_type pending_words [$];
   sps_rsp_type    expected_pulses [$];
   servo_word_type offered_word;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit long_hold_req = 1'b0;
   int hold_left = 0;
   int error_count = 0;
   int tick_count = 0;
   int width_writes = 0;
   int gap_count = 0;
   int frames_used = 0;

   servo_pulse_train_sequencer #(.CHANNELS(NUM_CHANNELS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // subtraction floored at zero
   function automatic logic [FRAME_W-1:0] floor_sub(input logic [FRAME_W-1:0] a,
                                                    input logic [FRAME_W-1:0] b);
      return (a > b) ? a - b : '0;
   endfunction

   function automatic logic [FRAME_W-1:0] width_of(input int unsigned idx);
      return (idx < NUM_CHANNELS) ? FRAME_W'(seq_widths[idx]) : '0;
   endfunction

   // advance the sequence for one accepted word, queue the pulse it yields
   function automatic void advance_sequence(input servo_word_type w);
      sps_rsp_type        pulse;
      logic [FRAME_W-1:0] period;
      pulse = '0;
      if (w.op == OP_WRITE) begin
         if (w.channel < NUM_CHANNELS) seq_widths[w.channel] = w.width_ticks;
         width_writes++;
         return;
      end
      tick_count++;
      if (seq_position == 0) begin
         seq_pins[PIN_RESET_FIRST] = 1'b0;
         seq_pins[PIN_DATA_FIRST]  = 1'b1;
         seq_side      = 1'b0;
         period        = width_of(0);
         seq_remaining = floor_sub(seq_frame, period);
         seq_position  = 4'd1;
      end else if (seq_position < STAGES_PER_REGISTER) begin
         seq_pins[PIN_DATA_FIRST] = 1'b0;
         period        = width_of(seq_position);
         seq_remaining = floor_sub(seq_remaining, period);
         seq_position++;
      end else if (seq_position == STAGES_PER_REGISTER) begin
         seq_pins[PIN_RESET_FIRST]  = 1'b1;
         seq_pins[PIN_RESET_SECOND] = 1'b0;
         seq_pins[PIN_DATA_SECOND]  = 1'b1;
         seq_side      = 1'b1;
         period        = width_of(seq_position);
         seq_remaining = floor_sub(seq_remaining, period);
         seq_position++;
      end else if (seq_position < NUM_CHANNELS) begin
         seq_pins[PIN_DATA_SECOND] = 1'b0;
         period        = width_of(seq_position);
         seq_remaining = floor_sub(seq_remaining, period);
         seq_position++;
      end else begin
         // end of frame: filler gap
         seq_pins[PIN_RESET_SECOND] = 1'b1;
         period        = seq_remaining;
         pulse.is_gap  = 1'b1;
         seq_position  = '0;
      end
      pulse.period_ticks    = period;
      pulse.clock_to_second = seq_side;
      pulse.reset_first     = seq_pins[PIN_RESET_FIRST];
      pulse.data_first      = seq_pins[PIN_DATA_FIRST];
      pulse.reset_second    = seq_pins[PIN_RESET_SECOND];
      pulse.data_second     = seq_pins[PIN_DATA_SECOND];
      expected_pulses.push_back(pulse);
   endfunction

   function automatic void check_field(input string name, input logic [FRAME_W-1:0] want,
                                       input logic [FRAME_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   // request driver, fed from the pending queue
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) advance_sequence(offered_word);
         if (!req_tvalid || req_tready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered_word = pending_words.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {5'b0, offered_word.width_ticks, offered_word.channel};
               req_tuser  <= offered_word.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result ready: random stalls plus one long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left = LONG_HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // result monitor
   always @(posedge clock) begin
      sps_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pulses.size() == 0) begin
            $error("result word with no expectation: period_ticks %0d", rsp_tdata[23:0]);
            error_count++;
         end else begin
            want = expected_pulses.pop_front();
            if (want.is_gap) gap_count++;
            check_field("period_ticks", want.period_ticks, rsp_tdata[23:0]);
            check_field("clock_to_second", FRAME_W'(want.clock_to_second),
                        FRAME_W'(rsp_tdata[24]));
            check_field("reset_first", FRAME_W'(want.reset_first), FRAME_W'(rsp_tdata[25]));
            check_field("data_first", FRAME_W'(want.data_first), FRAME_W'(rsp_tdata[26]));
            check_field("reset_second", FRAME_W'(want.reset_second),
                        FRAME_W'(rsp_tdata[27]));
            check_field("data_second", FRAME_W'(want.data_second), FRAME_W'(rsp_tdata[28]));
            check_field("is_gap", FRAME_W'(want.is_gap), FRAME_W'(rsp_tuser));
         end
      end
   end

   function automatic void push_word(input logic op, input int ch, input int w);
      servo_word_type word;
      word.op          = op;
      word.channel     = CHANNEL_W'(ch);
      word.width_ticks = WIDTH_W'(w);
      pending_words.push_back(word);
   endfunction

   // sender pause until the block is drained
   task automatic wait_drained();
      @(negedge clock);
      while (pending_words.size() != 0 || req_tvalid || expected_pulses.size() != 0)
         @(negedge clock);
   endtask

   task automatic set_frame(input logic [FRAME_W-1:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      seq_frame = value;
      @(posedge clock);
      csr_we <= 1'b0;
      frames_used++;
   endtask

   // mostly ticks, widths spread over servo range, full range and extremes
   task automatic run_chunk(input int count);
      int sel;
      int w;
      repeat (count) begin
         sel = $urandom_range(99);
         if (sel < 40)      w = $urandom_range(2100, 900);
         else if (sel < 90) w = $urandom_range(16'hFFFF);
         else               w = ($urandom_range(1) != 0) ? 16'hFFFF : 0;
         push_word(($urandom_range(99) < 70) ? OP_TICK : OP_WRITE, $urandom_range(7), w);
      end
      wait_drained();
   endtask

   initial begin
      // model state after reset
      foreach (seq_widths[i]) seq_widths[i] = MIDPOINT;
      seq_position  = '0;
      seq_remaining = '0;
      seq_pins      = '0;
      seq_side      = 1'b1;
      seq_frame     = FRAME_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 36;
      recv_idle_pct = 71;
      // directed: extreme widths, underflow at first channel, zero width, full frame
      push_word(OP_WRITE, 0, 16'hFFFF);
      push_word(OP_WRITE, 1, 0);
      repeat (9) push_word(OP_TICK, 0, 0);
      // underflow at the last channel
      push_word(OP_WRITE, 0, 1000);
      push_word(OP_WRITE, 7, 16'hFFFF);
      repeat (9) push_word(OP_TICK, 7, 16'hFFFF);
      wait_drained();

      set_frame('0);
      run_chunk(150);
      run_chunk(150);
      set_frame(24'hFFFFFF);
      long_hold_req = 1'b1;
      run_chunk(300);

      send_idle_pct = 71;
      recv_idle_pct = 36;
      set_frame(24'd20000);
      run_chunk(450);
      set_frame(FRAME_W'($urandom_range(24'hFFFFFF)));
      run_chunk(450);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_frame(24'd12000);
      run_chunk(450);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d ticks and %0d width writes over %0d frame lengths, %0d gap periods",
               tick_count, width_writes, frames_used + 1, gap_count);
      if (error_count == 0 && expected_pulses.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
